// ----- rtl/stt_pkg.sv -----
// shared types, codes and keyword table for the source text tokenizer
// no dependencies
package stt_pkg;

  localparam int unsigned MAX_WORD_LEN_DEF = 32;
  localparam int unsigned NUM_KW = 11;
  localparam logic [30:0] NUM_MAX = 31'h7fffffff;

  localparam logic [2:0] TK_SYM = 3'd0;
  localparam logic [2:0] TK_KW  = 3'd1;
  localparam logic [2:0] TK_ID  = 3'd2;
  localparam logic [2:0] TK_NUM = 3'd3;
  localparam logic [2:0] TK_ERR = 3'd4;

  localparam logic [4:0] SYM_MINUS   = 5'd0;
  localparam logic [4:0] SYM_DEC     = 5'd1;
  localparam logic [4:0] SYM_PLUS    = 5'd2;
  localparam logic [4:0] SYM_INC     = 5'd3;
  localparam logic [4:0] SYM_OR      = 5'd4;
  localparam logic [4:0] SYM_AND     = 5'd5;
  localparam logic [4:0] SYM_LESS    = 5'd6;
  localparam logic [4:0] SYM_LSHIFT  = 5'd7;
  localparam logic [4:0] SYM_GREATER = 5'd8;
  localparam logic [4:0] SYM_RSHIFT  = 5'd9;
  localparam logic [4:0] SYM_NOTEQ   = 5'd10;
  localparam logic [4:0] SYM_ASSIGN  = 5'd11;
  localparam logic [4:0] SYM_EQEQ    = 5'd12;
  localparam logic [4:0] SYM_SEMI    = 5'd13;
  localparam logic [4:0] SYM_COMMA   = 5'd14;
  localparam logic [4:0] SYM_LPAREN  = 5'd15;
  localparam logic [4:0] SYM_RPAREN  = 5'd16;
  localparam logic [4:0] SYM_LBRACE  = 5'd17;
  localparam logic [4:0] SYM_RBRACE  = 5'd18;

  localparam logic [1:0] ERR_UNKNOWN = 2'd0;
  localparam logic [1:0] ERR_BANG    = 2'd1;
  localparam logic [1:0] ERR_LONG    = 2'd2;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [4:0]  symbol_code;
    logic [3:0]  keyword_code;
    logic [30:0] number_value;
    logic        number_overflow;
    logic [7:0]  ident_char;
    logic [5:0]  ident_position;
    logic        token_done;
    logic [1:0]  error_code;
    logic        last_of_item;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind);
    res_t r;
    r = '0;
    r.token_kind = kind;
    r.token_done = 1'b1;
    return r;
  endfunction

  // keyword text, left aligned, zero padded
  function automatic logic [63:0] kw_text(logic [3:0] k);
    logic [63:0] t;
    case (k)
      4'd0:    t = "function";
      4'd1:    t = {"proto", 24'h0};
      4'd2:    t = {"val", 40'h0};
      4'd3:    t = {"void", 32'h0};
      4'd4:    t = {"byte", 32'h0};
      4'd5:    t = {"bool", 32'h0};
      4'd6:    t = {"local", 24'h0};
      4'd7:    t = {"global", 16'h0};
      4'd8:    t = {"if", 48'h0};
      4'd9:    t = {"while", 24'h0};
      4'd10:   t = {"return", 16'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_char(logic [3:0] k, logic [5:0] p);
    logic [63:0] s;
    s = kw_text(k) << {p[2:0], 3'b000};
    return (p < 6'd8) ? s[63:56] : 8'h00;
  endfunction

  function automatic logic [6:0] kw_len(logic [3:0] k);
    logic [6:0] n;
    case (k)
      4'd0:                      n = 7'd8;
      4'd1, 4'd6, 4'd9:          n = 7'd5;
      4'd2:                      n = 7'd3;
      4'd3, 4'd4, 4'd5:          n = 7'd4;
      4'd7, 4'd10:               n = 7'd6;
      4'd8:                      n = 7'd2;
      default:                   n = 7'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kw_code(logic [3:0] k);
    logic [3:0] c;
    case (k)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: c = k;
      4'd5:    c = 4'd4;
      default: c = k - 4'd1;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/stt_in_if.sv -----
// input channel of the tokenizer: one source character or end of text
// depends on nothing
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, kind, char_code, input ready);
  modport sink (input valid, kind, char_code, output ready);
endinterface

// ----- rtl/stt_out_if.sv -----
// output channel of the tokenizer: one token result per transaction
// depends on nothing
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [4:0]  symbol_code;
  logic [3:0]  keyword_code;
  logic [30:0] number_value;
  logic        number_overflow;
  logic [7:0]  ident_char;
  logic [5:0]  ident_position;
  logic        token_done;
  logic [1:0]  error_code;
  logic        last_of_item;
  modport source (output valid, token_kind, symbol_code, keyword_code, number_value,
                  number_overflow, ident_char, ident_position, token_done, error_code,
                  last_of_item, input ready);
  modport sink (input valid, token_kind, symbol_code, keyword_code, number_value,
                number_overflow, ident_char, ident_position, token_done, error_code,
                last_of_item, output ready);
endinterface

// ----- rtl/stt_kw_match.sv -----
// keyword candidate tracker, narrowed one character at a time as a word grows
// depends on stt_pkg
module stt_kw_match #(
  parameter int unsigned LW = 6
) (
  input  logic          clk,
  input  logic          first,
  input  logic          append,
  input  logic [5:0]    pos,
  input  logic [7:0]    ch,
  input  logic [LW-1:0] len,
  output logic          hit,
  output logic [3:0]    code
);
  logic [stt_pkg::NUM_KW-1:0] cand;

  always_ff @(posedge clk) begin
    for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
      if (first) begin
        cand[k] <= (stt_pkg::kw_char(4'(k), 6'd0) == ch);
      end else if (append) begin
        cand[k] <= cand[k] && (stt_pkg::kw_char(4'(k), pos) == ch);
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    code = '0;
    for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
      if (!hit && cand[k] && (7'(len) == stt_pkg::kw_len(4'(k)))) begin
        hit = 1'b1;
        code = stt_pkg::kw_code(4'(k));
      end
    end
  end
endmodule

// ----- rtl/source_text_tokenizer_top.sv -----
// source text tokenizer top level: sequencer, word buffer memory, output register
// depends on stt_pkg, stt_in_if, stt_out_if, stt_kw_match
//
// in_ch carries one source byte (kind 0) or an end-of-text mark (kind 1) per
// transaction; out_ch carries one token result per transaction, last_of_item
// marking the final result caused by an input transaction
// a held one-character lookahead resolves doubled operators and != ; words
// are kept in a word buffer memory (one write port, one registered read port)
// while a keyword candidate set is narrowed per character
// an input is taken in the idle state and resolved in the resolve state, which
// loads the held token's result into the output register; a result of a newly
// opened token is loaded in the start state that follows
// a character absorbed by the held token passes the idle and resolve states,
// one that opens a new token passes idle, resolve and start; an identifier
// flush adds a read state and an output register load state per character
// reset clears the lookahead class, word length, accumulator and output valid;
// the word buffer itself is not cleared, only entries written are ever read
// when out_ch stalls, the finished result holds in the output register and
// the sequencer waits; in_ch.ready is high only in the idle state, which is
// reached once the last result of the item is in the output register
module source_text_tokenizer_top #(
  parameter int unsigned MAX_WORD_LEN = stt_pkg::MAX_WORD_LEN_DEF
) (
  input logic clk,
  input logic rst,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(MAX_WORD_LEN);
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);

  typedef enum logic [3:0] {
    PC_NONE, PC_MINUS, PC_PLUS, PC_LESS, PC_GREATER, PC_BANG, PC_ASSIGN,
    PC_WORD, PC_SKIP, PC_NUMBER
  } pc_t;

  typedef enum logic [2:0] {S_IDLE, S_RESOLVE, S_START, S_WALK_RD, S_WALK_OUT} state_t;

  state_t        state;
  pc_t           pc;
  logic [LW-1:0] wlen;
  logic [30:0]   acc;
  logic          ovf;
  logic [7:0]    c;
  logic          eot;
  logic [LW-1:0] idx;
  logic [7:0]    rdata;
  logic          need_start;
  stt_pkg::res_t o;
  logic          o_valid;

  logic [7:0] wbuf [MAX_WORD_LEN];

  // character classes of the held byte
  logic is_a, is_d, is_ws, can_load;
  assign is_a = !eot && ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
  assign is_d = !eot && (c >= "0" && c <= "9");
  assign is_ws = (c == " ") || (c == 8'h09) || (c == 8'h0a);
  assign can_load = !o_valid || out_ch.ready;

  // result of opening a new token with the held byte
  logic          st_emit;
  stt_pkg::res_t st_res;
  always_comb begin
    st_emit = 1'b1;
    st_res = stt_pkg::mk_res(stt_pkg::TK_SYM);
    case (c) inside
      "|": st_res.symbol_code = stt_pkg::SYM_OR;
      "&": st_res.symbol_code = stt_pkg::SYM_AND;
      ";": st_res.symbol_code = stt_pkg::SYM_SEMI;
      ",": st_res.symbol_code = stt_pkg::SYM_COMMA;
      "(": st_res.symbol_code = stt_pkg::SYM_LPAREN;
      ")": st_res.symbol_code = stt_pkg::SYM_RPAREN;
      "{": st_res.symbol_code = stt_pkg::SYM_LBRACE;
      "}": st_res.symbol_code = stt_pkg::SYM_RBRACE;
      "-", "+", "<", ">", "!", "=", " ", 8'h09, 8'h0a: st_emit = 1'b0;
      default: begin
        if (is_a || is_d) begin
          st_emit = 1'b0;
        end else begin
          st_res = stt_pkg::mk_res(stt_pkg::TK_ERR);
          st_res.error_code = stt_pkg::ERR_UNKNOWN;
        end
      end
    endcase
    st_res.last_of_item = 1'b1;
  end

  // decimal accumulate, saturating
  logic [34:0] acc_mul;
  logic        acc_sat;
  assign acc_mul = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(c - "0");
  assign acc_sat = acc_mul > {4'b0, stt_pkg::NUM_MAX};

  // keyword candidates
  logic       kw_first, kw_append, kw_hit;
  logic [3:0] kw_code;
  assign kw_first = (state == S_START) && can_load && is_a;
  assign kw_append = (state == S_RESOLVE) && can_load && (pc == PC_WORD) &&
                     (is_a || is_d) && (wlen < LW'(MAX_WORD_LEN));

  stt_kw_match #(.LW(LW)) u_kw (
    .clk    (clk),
    .first  (kw_first),
    .append (kw_append),
    .pos    (6'(wlen)),
    .ch     (c),
    .len    (wlen),
    .hit    (kw_hit),
    .code   (kw_code)
  );

  // resolve the held class against the held byte
  logic          r_emit, r_cons, r_walk;
  stt_pkg::res_t r_res;
  always_comb begin
    r_emit = 1'b0;
    r_cons = 1'b0;
    r_walk = 1'b0;
    r_res = stt_pkg::mk_res(stt_pkg::TK_SYM);
    case (pc)
      PC_MINUS: begin
        r_emit = 1'b1;
        r_cons = !eot && c == "-";
        r_res.symbol_code = r_cons ? stt_pkg::SYM_DEC : stt_pkg::SYM_MINUS;
      end
      PC_PLUS: begin
        r_emit = 1'b1;
        r_cons = !eot && c == "+";
        r_res.symbol_code = r_cons ? stt_pkg::SYM_INC : stt_pkg::SYM_PLUS;
      end
      PC_LESS: begin
        r_emit = 1'b1;
        r_cons = !eot && c == "<";
        r_res.symbol_code = r_cons ? stt_pkg::SYM_LSHIFT : stt_pkg::SYM_LESS;
      end
      PC_GREATER: begin
        r_emit = 1'b1;
        r_cons = !eot && c == ">";
        r_res.symbol_code = r_cons ? stt_pkg::SYM_RSHIFT : stt_pkg::SYM_GREATER;
      end
      PC_ASSIGN: begin
        r_emit = 1'b1;
        r_cons = !eot && c == "=";
        r_res.symbol_code = r_cons ? stt_pkg::SYM_EQEQ : stt_pkg::SYM_ASSIGN;
      end
      PC_BANG: begin
        r_emit = 1'b1;
        r_cons = !eot && c == "=";
        if (r_cons) begin
          r_res.symbol_code = stt_pkg::SYM_NOTEQ;
        end else begin
          r_res = stt_pkg::mk_res(stt_pkg::TK_ERR);
          r_res.error_code = stt_pkg::ERR_BANG;
        end
      end
      PC_WORD: begin
        if (is_a || is_d) begin
          r_cons = 1'b1;
          if (wlen >= LW'(MAX_WORD_LEN)) begin
            r_emit = 1'b1;
            r_res = stt_pkg::mk_res(stt_pkg::TK_ERR);
            r_res.error_code = stt_pkg::ERR_LONG;
          end
        end else if (kw_hit) begin
          r_emit = 1'b1;
          r_res = stt_pkg::mk_res(stt_pkg::TK_KW);
          r_res.keyword_code = kw_code;
        end else begin
          r_walk = 1'b1;
        end
      end
      PC_SKIP: r_cons = is_a || is_d;
      PC_NUMBER: begin
        if (is_d) begin
          r_cons = 1'b1;
        end else begin
          r_emit = 1'b1;
          r_res = stt_pkg::mk_res(stt_pkg::TK_NUM);
          r_res.number_value = acc;
          r_res.number_overflow = ovf;
        end
      end
      default: ;
    endcase
  end

  logic r_need_start;
  assign r_need_start = !eot && !r_cons;

  // word buffer memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (kw_append) begin
      wbuf[wlen[AW-1:0]] <= c;
    end else if (kw_first) begin
      wbuf[0] <= c;
    end
    if (state == S_WALK_RD) begin
      rdata <= wbuf[idx[AW-1:0]];
    end
  end

  logic walk_done;
  assign walk_done = (idx + LW'(1)) == wlen;

  // next output register contents and load strobe
  stt_pkg::res_t o_next;
  logic          o_load;
  always_comb begin
    o_next = stt_pkg::mk_res(stt_pkg::TK_ID);
    o_next.ident_char = rdata;
    o_next.ident_position = 6'(idx);
    o_next.token_done = walk_done;
    o_next.last_of_item = walk_done && !(need_start && st_emit);
    o_load = 1'b0;
    case (state)
      S_RESOLVE: begin
        o_next = r_res;
        o_next.last_of_item = !(r_need_start && st_emit);
        o_load = can_load && r_emit;
      end
      S_START: begin
        o_next = st_res;
        o_load = can_load && st_emit;
      end
      S_WALK_OUT: o_load = can_load;
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= PC_NONE;
      wlen <= '0;
      acc <= '0;
      ovf <= 1'b0;
      o_valid <= 1'b0;
      idx <= '0;
      need_start <= 1'b0;
    end else begin
      if (o_load) begin
        o <= o_next;
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            c <= in_ch.char_code;
            eot <= in_ch.kind;
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (can_load) begin
            need_start <= r_need_start;
            idx <= '0;
            case (pc)
              PC_WORD: begin
                if (is_a || is_d) begin
                  if (wlen < LW'(MAX_WORD_LEN)) begin
                    wlen <= wlen + LW'(1);
                    pc <= PC_WORD;
                  end else begin
                    wlen <= '0;
                    pc <= PC_SKIP;
                  end
                end else begin
                  pc <= PC_NONE;
                  if (!r_walk) begin
                    wlen <= '0;
                  end
                end
              end
              PC_SKIP: pc <= r_cons ? PC_SKIP : PC_NONE;
              PC_NUMBER: begin
                if (is_d) begin
                  acc <= acc_sat ? stt_pkg::NUM_MAX : acc_mul[30:0];
                  ovf <= ovf | acc_sat;
                  pc <= PC_NUMBER;
                end else begin
                  acc <= '0;
                  ovf <= 1'b0;
                  pc <= PC_NONE;
                end
              end
              default: pc <= PC_NONE;
            endcase
            if (r_walk) begin
              state <= S_WALK_RD;
            end else if (r_need_start) begin
              state <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_START: begin
          if (can_load) begin
            if (!is_ws) begin
              case (c)
                "-": pc <= PC_MINUS;
                "+": pc <= PC_PLUS;
                "<": pc <= PC_LESS;
                ">": pc <= PC_GREATER;
                "!": pc <= PC_BANG;
                "=": pc <= PC_ASSIGN;
                default: begin
                  if (is_a) begin
                    wlen <= LW'(1);
                    pc <= PC_WORD;
                  end else if (is_d) begin
                    acc <= 31'(c - "0");
                    ovf <= 1'b0;
                    pc <= PC_NUMBER;
                  end
                end
              endcase
            end
            state <= S_IDLE;
          end
        end
        S_WALK_RD: state <= S_WALK_OUT;
        S_WALK_OUT: begin
          if (can_load) begin
            idx <= idx + LW'(1);
            if (walk_done) begin
              wlen <= '0;
              state <= need_start ? S_START : S_IDLE;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  assign out_ch.valid = o_valid;
  assign out_ch.token_kind = o.token_kind;
  assign out_ch.symbol_code = o.symbol_code;
  assign out_ch.keyword_code = o.keyword_code;
  assign out_ch.number_value = o.number_value;
  assign out_ch.number_overflow = o.number_overflow;
  assign out_ch.ident_char = o.ident_char;
  assign out_ch.ident_position = o.ident_position;
  assign out_ch.token_done = o.token_done;
  assign out_ch.error_code = o.error_code;
  assign out_ch.last_of_item = o.last_of_item;
endmodule
